>>> rtl/core/lcpf_pkg.sv
// Shared types and constants for the LJ/Coulomb pair force block.
// Holds the sequencer states, the microcode format and the microprogram.
// Depends on nothing; every other file of the block imports it.
package lcpf_pkg;

    localparam int PC_W = 6;

    localparam logic [2:0] CFG_MODE          = 3'd0;
    localparam logic [2:0] CFG_CUTOFF        = 3'd1;
    localparam logic [2:0] CFG_INV_CUTOFF_SQ = 3'd2;
    localparam logic [2:0] CFG_COULOMB_SCALE = 3'd3;
    localparam logic [2:0] CFG_RF_ENERGY     = 3'd4;
    localparam logic [2:0] CFG_RF_FORCE      = 3'd5;

    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_SHIFTED = 2'd1;
    localparam logic [1:0] MODE_GRF     = 2'd2;

    localparam logic [PC_W-1:0] PC_PLAIN   = 6'd9;
    localparam logic [PC_W-1:0] PC_SHIFTED = 6'd12;
    localparam logic [PC_W-1:0] PC_GRF     = 6'd19;
    localparam logic [PC_W-1:0] PC_TAIL    = 6'd25;
    localparam logic [PC_W-1:0] PC_LAST    = 6'd37;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQW,
        S_ROOT,
        S_CHECK,
        S_DIV,
        S_PROG,
        S_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_BRANCH,
        OP_GOTO,
        OP_END
    } op_t;

    typedef enum logic [4:0] {
        SRC_ZERO,
        SRC_SIX,
        SRC_INV,
        SRC_T0,
        SRC_T1,
        SRC_R6,
        SRC_A,
        SRC_B,
        SRC_K,
        SRC_Q,
        SRC_KQ,
        SRC_EST,
        SRC_ICS,
        SRC_RR,
        SRC_DC,
        SRC_B0,
        SRC_B1,
        SRC_LJA,
        SRC_LJB,
        SRC_CE,
        SRC_CF,
        SRC_FM,
        SRC_CSUM,
        SRC_VSUM,
        SRC_DX,
        SRC_DY,
        SRC_DZ
    } src_t;

    typedef enum logic [3:0] {
        DST_T0,
        DST_T1,
        DST_R6,
        DST_LJA,
        DST_LJB,
        DST_KQ,
        DST_EST,
        DST_CE,
        DST_CF,
        DST_FM,
        DST_CSUM,
        DST_VSUM,
        DST_FX,
        DST_FY,
        DST_FZ
    } dst_t;

    typedef enum logic [2:0] {
        SH_0,
        SH_8,
        SH_16,
        SH_24,
        SH_32,
        SH_40,
        SH_COORD
    } shift_t;

    typedef struct packed {
        op_t    op;
        src_t   src_a;
        src_t   src_b;
        shift_t sh;
        dst_t   dst;
    } uop_t;

    typedef struct packed {
        logic   start;
        shift_t sh;
    } mul_req_t;

    function automatic uop_t mk(op_t op, src_t a, src_t b, shift_t sh, dst_t dst);
        uop_t u;
        u.op    = op;
        u.src_a = a;
        u.src_b = b;
        u.sh    = sh;
        u.dst   = dst;
        return u;
    endfunction

    // Microprogram for an in-range pair. The common head builds 1/r
    // powers, LJ terms and k*q/r, then branches on electrostatics mode.
    function automatic uop_t ucode(logic [PC_W-1:0] pc);
        uop_t u;
        u = mk(OP_END, SRC_ZERO, SRC_ZERO, SH_0, DST_T0);
        case (pc)
            6'd0:  u = mk(OP_MUL, SRC_INV, SRC_INV, SH_40, DST_T0);
            6'd1:  u = mk(OP_MUL, SRC_T0, SRC_T0, SH_40, DST_T1);
            6'd2:  u = mk(OP_MUL, SRC_T1, SRC_T0, SH_40, DST_R6);
            6'd3:  u = mk(OP_MUL, SRC_R6, SRC_R6, SH_40, DST_T1);
            6'd4:  u = mk(OP_MUL, SRC_A, SRC_T1, SH_32, DST_LJA);
            6'd5:  u = mk(OP_MUL, SRC_B, SRC_R6, SH_32, DST_LJB);
            6'd6:  u = mk(OP_MUL, SRC_K, SRC_Q, SH_8, DST_KQ);
            6'd7:  u = mk(OP_MUL, SRC_KQ, SRC_INV, SH_40, DST_EST);
            6'd8:  u = mk(OP_BRANCH, SRC_ZERO, SRC_ZERO, SH_0, DST_T0);
            6'd9:  u = mk(OP_ADD, SRC_EST, SRC_ZERO, SH_0, DST_CE);
            6'd10: u = mk(OP_MUL, SRC_EST, SRC_INV, SH_40, DST_CF);
            6'd11: u = mk(OP_GOTO, SRC_ZERO, SRC_ZERO, SH_0, DST_T0);
            6'd12: u = mk(OP_MUL, SRC_DC, SRC_DC, SH_8, DST_T0);
            6'd13: u = mk(OP_MUL, SRC_T0, SRC_ICS, SH_32, DST_T0);
            6'd14: u = mk(OP_MUL, SRC_EST, SRC_T0, SH_24, DST_CE);
            6'd15: u = mk(OP_MUL, SRC_ICS, SRC_RR, SH_8, DST_T1);
            6'd16: u = mk(OP_SUB, SRC_INV, SRC_T1, SH_0, DST_T1);
            6'd17: u = mk(OP_MUL, SRC_EST, SRC_T1, SH_40, DST_CF);
            6'd18: u = mk(OP_GOTO, SRC_ZERO, SRC_ZERO, SH_0, DST_T0);
            6'd19: u = mk(OP_MUL, SRC_KQ, SRC_B0, SH_24, DST_T0);
            6'd20: u = mk(OP_ADD, SRC_EST, SRC_T0, SH_0, DST_CE);
            6'd21: u = mk(OP_MUL, SRC_EST, SRC_INV, SH_40, DST_T0);
            6'd22: u = mk(OP_MUL, SRC_KQ, SRC_B1, SH_24, DST_T1);
            6'd23: u = mk(OP_MUL, SRC_T1, SRC_RR, SH_16, DST_T1);
            6'd24: u = mk(OP_ADD, SRC_T0, SRC_T1, SH_0, DST_CF);
            6'd25: u = mk(OP_ADD, SRC_LJA, SRC_LJA, SH_0, DST_T0);
            6'd26: u = mk(OP_SUB, SRC_T0, SRC_LJB, SH_0, DST_T0);
            6'd27: u = mk(OP_MUL, SRC_T0, SRC_INV, SH_40, DST_T0);
            6'd28: u = mk(OP_MUL, SRC_T0, SRC_SIX, SH_0, DST_T0);
            6'd29: u = mk(OP_ADD, SRC_CF, SRC_T0, SH_0, DST_T0);
            6'd30: u = mk(OP_MUL, SRC_T0, SRC_INV, SH_40, DST_FM);
            6'd31: u = mk(OP_ADD, SRC_CSUM, SRC_CE, SH_0, DST_CSUM);
            6'd32: u = mk(OP_SUB, SRC_LJA, SRC_LJB, SH_0, DST_T1);
            6'd33: u = mk(OP_ADD, SRC_VSUM, SRC_T1, SH_0, DST_VSUM);
            6'd34: u = mk(OP_MUL, SRC_FM, SRC_DX, SH_COORD, DST_FX);
            6'd35: u = mk(OP_MUL, SRC_FM, SRC_DY, SH_COORD, DST_FY);
            6'd36: u = mk(OP_MUL, SRC_FM, SRC_DZ, SH_COORD, DST_FZ);
            default: u = mk(OP_END, SRC_ZERO, SRC_ZERO, SH_0, DST_T0);
        endcase
        return u;
    endfunction

endpackage

>>> rtl/core/lj_coulomb_pair_force.sv
// Lennard-Jones 12-6 plus Coulomb pair force with cutoff, fixed point.
// Top level: sequencer, square root, divider and microprogram around one
// shared multiplier (lcpf_mul_unit). Depends on lcpf_pkg.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  item    | item_valid / item_stall | atoms, coordinates, coefficients, start_sum
//  result  | result_valid / result_stall | atoms, forces, distance, sums
//
// A pair beyond the cutoff takes three squares on the multiplier and a
// 33-step square root. An in-range pair adds a 57-step divider for 1/r
// and a microprogram of 15 to 19 multiplies.
// Reset restores the register defaults and clears both energy sums.
// A finished transaction waits in the result register while the next pair
// is accepted; a stalled result holds the block only when it must hand
// over a second one.
module lj_coulomb_pair_force #(
    parameter int ATOM_COUNT      = 4096,
    parameter int COORD_FRAC_BITS = 16,
    localparam int IDX_W          = $clog2(ATOM_COUNT)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [IDX_W-1:0]         first_atom,
    input  logic [IDX_W-1:0]         second_atom,
    input  logic signed [31:0]       first_x,
    input  logic signed [31:0]       first_y,
    input  logic signed [31:0]       first_z,
    input  logic signed [31:0]       second_x,
    input  logic signed [31:0]       second_y,
    input  logic signed [31:0]       second_z,
    input  logic [39:0]              repulsive_coef,
    input  logic [39:0]              attractive_coef,
    input  logic signed [23:0]       charge_product,
    input  logic                     start_sum,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [IDX_W-1:0]         out_first_atom,
    output logic [IDX_W-1:0]         out_second_atom,
    output logic signed [47:0]       force_x,
    output logic signed [47:0]       force_y,
    output logic signed [47:0]       force_z,
    output logic [31:0]              distance,
    output logic                     in_range,
    output logic signed [63:0]       vdw_total,
    output logic signed [63:0]       coulomb_total
);
    import lcpf_pkg::*;

    state_t state_reg, state_next;

    logic [1:0]         mode_reg;
    logic [31:0]        cutoff_reg;
    logic [31:0]        ics_reg;
    logic [31:0]        kscale_reg;
    logic signed [31:0] b0_reg;
    logic signed [31:0] b1_reg;

    logic [IDX_W-1:0]   atom1_reg;
    logic [IDX_W-1:0]   atom2_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic signed [32:0] dz_reg;
    logic [39:0]        a_reg;
    logic [39:0]        b_reg;
    logic signed [23:0] q_reg;

    logic [1:0]         axis_reg;
    logic [65:0]        sq_sum_reg;
    logic [65:0]        rad_reg;
    logic [34:0]        srem_reg;
    logic [32:0]        root_reg;
    logic [5:0]         iter_reg;
    logic [31:0]        rr_reg;
    logic               inr_reg;
    logic [31:0]        drem_reg;
    logic [56:0]        quo_reg;
    logic [PC_W-1:0]    pc_reg;

    logic signed [63:0] t0_reg, t1_reg, r6_reg, lja_reg, ljb_reg, kq_reg, est_reg;
    logic signed [63:0] ce_reg, cf_reg, fm_reg, csum_reg, vsum_reg;
    logic signed [47:0] fx_reg, fy_reg, fz_reg;

    logic               res_valid_reg;
    logic [IDX_W-1:0]   res_atom1_reg, res_atom2_reg;
    logic signed [47:0] res_fx_reg, res_fy_reg, res_fz_reg;
    logic [31:0]        res_dist_reg;
    logic               res_inr_reg;
    logic signed [63:0] res_vdw_reg, res_coul_reg;

    uop_t               uop;
    mul_req_t           mul_req;
    logic signed [63:0] mul_a, mul_b, mul_product;
    logic [127:0]       mul_raw;
    logic               mul_done;

    logic               item_acc;
    logic               out_load;
    logic               wb_en;
    logic signed [63:0] wb_val;
    logic signed [63:0] opa, opb;
    logic signed [63:0] axis_d;
    logic [65:0]        sq_add;
    logic [34:0]        srem_sh;
    logic [34:0]        strial;
    logic [32:0]        drem_sh;
    logic [40:0]        rq_wide;
    logic [31:0]        rq;
    logic signed [33:0] dc;

    function automatic logic signed [63:0] sat_add(
        input logic signed [63:0] x,
        input logic signed [63:0] y,
        input logic               sub
    );
        logic signed [64:0] s;
        s = sub ? ({x[63], x} - {y[63], y}) : ({x[63], x} + {y[63], y});
        if (s[64] != s[63]) begin
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
        if (v[63:47] != {17{v[63]}}) begin
            return v[63] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end
        return v[47:0];
    endfunction

    function automatic logic signed [63:0] pick(input src_t s);
        case (s)
            SRC_SIX:  return 64'sd6;
            SRC_INV:  return {7'd0, quo_reg};
            SRC_T0:   return t0_reg;
            SRC_T1:   return t1_reg;
            SRC_R6:   return r6_reg;
            SRC_A:    return {24'd0, a_reg};
            SRC_B:    return {24'd0, b_reg};
            SRC_K:    return {32'd0, kscale_reg};
            SRC_Q:    return 64'(q_reg);
            SRC_KQ:   return kq_reg;
            SRC_EST:  return est_reg;
            SRC_ICS:  return {32'd0, ics_reg};
            SRC_RR:   return {32'd0, rr_reg};
            SRC_DC:   return 64'(dc);
            SRC_B0:   return 64'(b0_reg);
            SRC_B1:   return 64'(b1_reg);
            SRC_LJA:  return lja_reg;
            SRC_LJB:  return ljb_reg;
            SRC_CE:   return ce_reg;
            SRC_CF:   return cf_reg;
            SRC_FM:   return fm_reg;
            SRC_CSUM: return csum_reg;
            SRC_VSUM: return vsum_reg;
            SRC_DX:   return 64'(dx_reg);
            SRC_DY:   return 64'(dy_reg);
            SRC_DZ:   return 64'(dz_reg);
            default:  return 64'sd0;
        endcase
    endfunction

    lcpf_mul_unit #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product),
        .raw     (mul_raw)
    );

    // Datapath helpers.
    always_comb begin
        uop      = ucode(pc_reg);
        opa      = pick(uop.src_a);
        opb      = pick(uop.src_b);
        dc       = {2'b00, cutoff_reg} - {2'b00, rr_reg};
        case (axis_reg)
            2'd0:    axis_d = 64'(dx_reg);
            2'd1:    axis_d = 64'(dy_reg);
            default: axis_d = 64'(dz_reg);
        endcase
        sq_add   = sq_sum_reg + mul_raw[65:0];
        srem_sh  = {srem_reg[32:0], rad_reg[65:64]};
        strial   = {root_reg[32:0], 2'b01};
        drem_sh  = {drem_reg, quo_reg[56]};
        rq_wide  = {root_reg, 8'd0} >> (COORD_FRAC_BITS - 8);
        rq       = (|rq_wide[40:32]) ? 32'hFFFF_FFFF : rq_wide[31:0];
        wb_val   = (state_reg == S_WAIT) ? mul_product
                                         : sat_add(opa, opb, uop.op == OP_SUB);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (item_acc) state_next = S_SQ;
            S_SQ:    state_next = S_SQW;
            S_SQW:   if (mul_done) state_next = (axis_reg == 2'd2) ? S_ROOT : S_SQ;
            S_ROOT:  if (iter_reg == 6'd32) state_next = S_CHECK;
            S_CHECK: state_next = (rq != 32'd0 && rq <= cutoff_reg) ? S_DIV : S_OUT;
            S_DIV:   if (iter_reg == 6'd56) state_next = S_PROG;
            S_PROG: begin
                if (uop.op == OP_MUL) begin
                    state_next = S_WAIT;
                end else if (uop.op == OP_END) begin
                    state_next = S_OUT;
                end
            end
            S_WAIT:  if (mul_done) state_next = S_PROG;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        item_stall    = (state_reg != S_IDLE);
        item_acc      = item_valid && !item_stall;
        out_load      = (state_reg == S_OUT) && (!res_valid_reg || !result_stall);
        mul_req.start = (state_reg == S_SQ) || (state_reg == S_PROG && uop.op == OP_MUL);
        mul_req.sh    = (state_reg == S_SQ) ? SH_0 : uop.sh;
        mul_a         = (state_reg == S_SQ) ? axis_d : opa;
        mul_b         = (state_reg == S_SQ) ? axis_d : opb;
        wb_en         = (state_reg == S_WAIT && mul_done) ||
                        (state_reg == S_PROG && (uop.op == OP_ADD || uop.op == OP_SUB));
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_PLAIN;
            cutoff_reg    <= 32'd786432;
            ics_reg       <= 32'd29826162;
            kscale_reg    <= 32'd21762127;
            b0_reg        <= 32'sd0;
            b1_reg        <= 32'sd0;
            csum_reg      <= 64'sd0;
            vsum_reg      <= 64'sd0;
            res_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_MODE:          mode_reg   <= cfg_data[1:0];
                    CFG_CUTOFF:        cutoff_reg <= cfg_data;
                    CFG_INV_CUTOFF_SQ: ics_reg    <= cfg_data;
                    CFG_COULOMB_SCALE: kscale_reg <= cfg_data;
                    CFG_RF_ENERGY:     b0_reg     <= cfg_data;
                    CFG_RF_FORCE:      b1_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (item_acc && start_sum) begin
                csum_reg <= 64'sd0;
                vsum_reg <= 64'sd0;
            end else if (wb_en && uop.dst == DST_CSUM) begin
                csum_reg <= wb_val;
            end else if (wb_en && uop.dst == DST_VSUM) begin
                vsum_reg <= wb_val;
            end
            if (state_reg == S_DIV) begin
                pc_reg <= '0;
            end else if (state_reg == S_PROG) begin
                case (uop.op)
                    OP_ADD, OP_SUB: pc_reg <= pc_reg + PC_W'(1);
                    OP_GOTO:        pc_reg <= PC_TAIL;
                    OP_BRANCH: begin
                        case (mode_reg)
                            MODE_SHIFTED: pc_reg <= PC_SHIFTED;
                            MODE_GRF:     pc_reg <= PC_GRF;
                            default:      pc_reg <= PC_PLAIN;
                        endcase
                    end
                    default: ;
                endcase
            end else if (state_reg == S_WAIT && mul_done) begin
                pc_reg <= pc_reg + PC_W'(1);
            end
            if (out_load) begin
                res_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (item_acc) begin
            atom1_reg  <= first_atom;
            atom2_reg  <= second_atom;
            dx_reg     <= 33'(first_x) - 33'(second_x);
            dy_reg     <= 33'(first_y) - 33'(second_y);
            dz_reg     <= 33'(first_z) - 33'(second_z);
            a_reg      <= repulsive_coef;
            b_reg      <= attractive_coef;
            q_reg      <= charge_product;
            axis_reg   <= 2'd0;
            sq_sum_reg <= 66'd0;
            fx_reg     <= 48'sd0;
            fy_reg     <= 48'sd0;
            fz_reg     <= 48'sd0;
        end
        if (state_reg == S_SQW && mul_done) begin
            sq_sum_reg <= sq_add;
            axis_reg   <= axis_reg + 2'd1;
            rad_reg    <= sq_add;
            srem_reg   <= 35'd0;
            root_reg   <= 33'd0;
            iter_reg   <= 6'd0;
        end
        // One root bit per cycle from the sum of squares.
        if (state_reg == S_ROOT) begin
            rad_reg  <= {rad_reg[63:0], 2'b00};
            iter_reg <= iter_reg + 6'd1;
            if (srem_sh >= strial) begin
                srem_reg <= srem_sh - strial;
                root_reg <= {root_reg[31:0], 1'b1};
            end else begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[31:0], 1'b0};
            end
        end
        // Rounded 2^56 / r starts from the dividend 2^56 + r/2.
        if (state_reg == S_CHECK) begin
            rr_reg   <= rq;
            inr_reg  <= (rq != 32'd0) && (rq <= cutoff_reg);
            quo_reg  <= {1'b1, 56'd0} + {26'd0, rq[31:1]};
            drem_reg <= 32'd0;
            iter_reg <= 6'd0;
        end
        if (state_reg == S_DIV) begin
            iter_reg <= iter_reg + 6'd1;
            if (drem_sh >= {1'b0, rr_reg}) begin
                drem_reg <= 32'(drem_sh - {1'b0, rr_reg});
                quo_reg  <= {quo_reg[55:0], 1'b1};
            end else begin
                drem_reg <= drem_sh[31:0];
                quo_reg  <= {quo_reg[55:0], 1'b0};
            end
        end
        if (wb_en) begin
            case (uop.dst)
                DST_T0:  t0_reg  <= wb_val;
                DST_T1:  t1_reg  <= wb_val;
                DST_R6:  r6_reg  <= wb_val;
                DST_LJA: lja_reg <= wb_val;
                DST_LJB: ljb_reg <= wb_val;
                DST_KQ:  kq_reg  <= wb_val;
                DST_EST: est_reg <= wb_val;
                DST_CE:  ce_reg  <= wb_val;
                DST_CF:  cf_reg  <= wb_val;
                DST_FM:  fm_reg  <= wb_val;
                DST_FX:  fx_reg  <= clamp48(wb_val);
                DST_FY:  fy_reg  <= clamp48(wb_val);
                DST_FZ:  fz_reg  <= clamp48(wb_val);
                default: ;
            endcase
        end
        if (out_load) begin
            res_atom1_reg <= atom1_reg;
            res_atom2_reg <= atom2_reg;
            res_fx_reg    <= fx_reg;
            res_fy_reg    <= fy_reg;
            res_fz_reg    <= fz_reg;
            res_dist_reg  <= rr_reg;
            res_inr_reg   <= inr_reg;
            res_vdw_reg   <= vsum_reg;
            res_coul_reg  <= csum_reg;
        end
    end

    assign cfg_ready       = 1'b1;
    assign result_valid    = res_valid_reg;
    assign out_first_atom  = res_atom1_reg;
    assign out_second_atom = res_atom2_reg;
    assign force_x         = res_fx_reg;
    assign force_y         = res_fy_reg;
    assign force_z         = res_fz_reg;
    assign distance        = res_dist_reg;
    assign in_range        = res_inr_reg;
    assign vdw_total       = res_vdw_reg;
    assign coulomb_total   = res_coul_reg;

    property p_in_range_nonzero;
        @(posedge clk) disable iff (!rst_n)
        (result_valid && in_range) |-> distance != 32'd0;
    endproperty
    assert property (p_in_range_nonzero)
        else $error("in-range result with zero distance");

    property p_out_of_range_no_force;
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !in_range) |->
            (force_x == 48'sd0 && force_y == 48'sd0 && force_z == 48'sd0);
    endproperty
    assert property (p_out_of_range_no_force)
        else $error("force reported for a pair beyond the cutoff");

    property p_mul_done_expected;
        @(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_WAIT || state_reg == S_SQW);
    endproperty
    assert property (p_mul_done_expected)
        else $error("multiplier finished while the sequencer was not waiting");

    property p_pc_bounded;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROG || state_reg == S_WAIT) |-> pc_reg <= PC_LAST;
    endproperty
    assert property (p_pc_bounded)
        else $error("microprogram counter ran past the end");

    property p_result_from_out_state;
        @(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == S_OUT;
    endproperty
    assert property (p_result_from_out_state)
        else $error("result appeared without the sequencer finishing");

endmodule

>>> rtl/core/lcpf_mul_unit.sv
// Shared signed multiplier: 64x64 magnitudes as four 32x32 partial
// products, then rounding (ties away from zero), shift and saturation.
// Depends on lcpf_pkg for the request struct and shift codes.
module lcpf_mul_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lcpf_pkg::mul_req_t       req,
    input  logic signed [63:0]       a,
    input  logic signed [63:0]       b,
    output logic                     done,
    output logic signed [63:0]       product,
    output logic [127:0]             raw
);
    import lcpf_pkg::*;

    logic           busy_reg;
    logic [2:0]     step_reg;
    logic [63:0]    ma_reg;
    logic [63:0]    mb_reg;
    logic           neg_reg;
    shift_t         sh_reg;
    logic [127:0]   acc_reg;
    logic           over_reg;
    logic [63:0]    lo_reg;
    logic           done_reg;
    logic signed [63:0] product_reg;

    logic [31:0]    a_half;
    logic [31:0]    b_half;
    logic [63:0]    pp;
    logic [127:0]   pp_shifted;
    logic [6:0]     shamt;
    logic [127:0]   half;
    logic [127:0]   rnd;
    logic [127:0]   sft;
    logic [63:0]    lim;
    logic [63:0]    sat_mag;

    always_comb begin
        a_half = step_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        b_half = step_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp     = a_half * b_half;
        case (step_reg[1:0])
            2'd0:    pp_shifted = {64'd0, pp};
            2'd3:    pp_shifted = {pp, 64'd0};
            default: pp_shifted = {32'd0, pp, 32'd0};
        endcase
        case (sh_reg)
            SH_8:     shamt = 7'd8;
            SH_16:    shamt = 7'd16;
            SH_24:    shamt = 7'd24;
            SH_32:    shamt = 7'd32;
            SH_40:    shamt = 7'd40;
            SH_COORD: shamt = 7'(COORD_FRAC_BITS);
            default:  shamt = 7'd0;
        endcase
        half    = (shamt == 7'd0) ? 128'd0 : (128'd1 << (shamt - 7'd1));
        rnd     = acc_reg + half;
        sft     = rnd >> shamt;
        lim     = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        sat_mag = (over_reg || (lo_reg > lim)) ? lim : lo_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                if (step_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (req.start && !busy_reg) begin
            ma_reg  <= a[63] ? 64'(-a) : 64'(a);
            mb_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] != b[63];
            sh_reg  <= req.sh;
            acc_reg <= 128'd0;
        end else if (busy_reg) begin
            if (step_reg <= 3'd3) begin
                acc_reg <= acc_reg + pp_shifted;
            end else if (step_reg == 3'd4) begin
                over_reg <= |sft[127:64];
                lo_reg   <= sft[63:0];
            end else begin
                product_reg <= neg_reg ? -$signed(sat_mag) : $signed(sat_mag);
            end
        end
    end

    assign done    = done_reg;
    assign product = product_reg;
    assign raw     = acc_reg;

    always_ff @(posedge clk) begin
        if (rst_n) begin
            assert (!(done_reg && busy_reg))
                else $error("multiplier reports done while still busy");
        end
    end

    property p_done_after_final_step;
        @(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(step_reg) == 3'd5;
    endproperty
    assert property (p_done_after_final_step)
        else $error("multiplier done without final step");

    property p_step_range;
        @(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= 3'd5;
    endproperty
    assert property (p_step_range)
        else $error("multiplier step out of range");

endmodule
